// File: rtl/prim_minimum_spanning_tree_core_defines.svh
// assertion macros shared by the spanning tree core rtl
`ifndef PRIM_MINIMUM_SPANNING_TREE_CORE_DEFINES_SVH
`define PRIM_MINIMUM_SPANNING_TREE_CORE_DEFINES_SVH

`ifndef SYNTH
// antecedent holds, consequent holds in the same cycle
`define PMST_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent holds, consequent holds in the cycle after
`define PMST_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PMST_ASSERT_IMP(name, ante, cons, msg)
`define PMST_ASSERT_NXT(name, ante, cons, msg)
`endif

`endif

// File: rtl/pmst_pkg.sv
// shared types and constants of the spanning tree core
package pmst_pkg;

    localparam int VERTEX_W    = 4;
    localparam int WEIGHT_IN_W = 16;
    localparam int COST_W      = 20;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    // register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] REG_START_VERTEX = 2'd1;
    localparam logic [1:0] REG_DIRECTED     = 2'd2;

    localparam logic [4:0] VERTEX_COUNT_RST = 5'd16;
    localparam logic [3:0] START_VERTEX_RST = 4'd0;
    localparam logic       DIRECTED_RST     = 1'b0;

    localparam logic [COST_W-1:0] COST_MAX = 20'hFFFFF;

    typedef struct packed {
        logic [4:0] vertex_count;
        logic [3:0] start_vertex;
        logic       directed;
    } cfg_t;

    typedef struct packed {
        logic [VERTEX_W-1:0]    parent_vertex;
        logic [VERTEX_W-1:0]    child_vertex;
        logic [WEIGHT_IN_W-1:0] tree_edge_weight;
        logic                   reached;
        logic [COST_W-1:0]      total_cost;
        logic                   last;
    } result_t;

endpackage

// File: rtl/pmst_cfg.sv
// apb configuration registers of the spanning tree core
module pmst_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pmst_pkg::ADDR_W-1:0] paddr,
    input  logic [pmst_pkg::DATA_W-1:0] pwdata,
    output logic [pmst_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output pmst_pkg::cfg_t              cfg
);
    import pmst_pkg::*;

    logic [4:0] vertex_count_reg;
    logic [3:0] start_vertex_reg;
    logic       directed_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VERTEX_COUNT_RST;
            start_vertex_reg <= START_VERTEX_RST;
            directed_reg     <= DIRECTED_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_VERTEX_COUNT: vertex_count_reg <= pwdata[4:0];
                REG_START_VERTEX: start_vertex_reg <= pwdata[3:0];
                REG_DIRECTED:     directed_reg     <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_VERTEX_COUNT: prdata = DATA_W'(vertex_count_reg);
            REG_START_VERTEX: prdata = DATA_W'(start_vertex_reg);
            REG_DIRECTED:     prdata = DATA_W'(directed_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.vertex_count = vertex_count_reg;
    assign cfg.start_vertex = start_vertex_reg;
    assign cfg.directed     = directed_reg;

endmodule

// File: rtl/pmst_engine.sv
// edge store, vertex table and prim sequencer of the spanning tree core
`include "prim_minimum_spanning_tree_core_defines.svh"

module pmst_engine #(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pmst_pkg::cfg_t                   cfg,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             req_type,
    input  logic [pmst_pkg::VERTEX_W-1:0]    from_vertex,
    input  logic [pmst_pkg::VERTEX_W-1:0]    to_vertex,
    input  logic [pmst_pkg::WEIGHT_IN_W-1:0] edge_weight,
    input  logic                             out_free,
    output logic                             push,
    output pmst_pkg::result_t                push_data
);
    import pmst_pkg::*;

    localparam int VW     = $clog2(MAX_VERTICES);
    localparam int AW     = 2 * VW;
    localparam int EDEPTH = 1 << AW;
    localparam int VDEPTH = 1 << VW;
    localparam int DW     = WEIGHT_BITS + 1;
    localparam int NMAX   = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
    localparam int SW     = ((DW > COST_W) ? DW : COST_W) + 1;

    localparam logic [5:0]    NMAX_N   = 6'(NMAX);
    localparam logic [DW-1:0] DIST_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_EWR1   = 4'd2;
    localparam logic [3:0] S_ERD2   = 4'd3;
    localparam logic [3:0] S_EWR2   = 4'd4;
    localparam logic [3:0] S_PISSUE = 4'd5;
    localparam logic [3:0] S_PFIN   = 4'd6;
    localparam logic [3:0] S_RRD    = 4'd7;
    localparam logic [3:0] S_RLOAD  = 4'd8;
    localparam logic [3:0] S_SUM    = 4'd9;

    typedef struct packed {
        logic          tree;
        logic [VW-1:0] parent;
        logic [DW-1:0] weight;
    } vent_t;

    // memories
    logic [DW-1:0] emem [EDEPTH];
    vent_t         vmem [VDEPTH];
    logic [DW-1:0] erdata_reg;
    vent_t         vrdata_reg;

    logic          e_we, e_re;
    logic [AW-1:0] e_waddr, e_raddr;
    logic [DW-1:0] e_wdata;
    logic          v_we, v_re;
    logic [VW-1:0] v_waddr, v_raddr;
    vent_t         v_wdata;

    // control
    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [VW-1:0] v_reg, v_next;
    logic [VW-1:0] k_reg, k_next;
    logic [VW-1:0] nl_reg, nl_next;
    logic [VW-1:0] s_reg, s_next;
    logic          first_reg, first_next;
    logic [DW-1:0] best_d_reg, best_d_next;
    logic [VW-1:0] best_v_reg, best_v_next;
    logic          found_reg, found_next;
    logic          p_vld_reg, p_vld_next;
    logic [VW-1:0] p_k_reg, p_k_next;
    logic [COST_W-1:0] total_reg, total_next;
    logic          dir_reg, dir_next;

    // edge payload
    logic [VW-1:0]          a_reg, a_next;
    logic [VW-1:0]          b_reg, b_next;
    logic [WEIGHT_BITS-1:0] w_reg, w_next;

    logic          accept;
    logic          edge_ok;
    logic [5:0]    n_run;
    logic [VW-1:0] nl_run;
    logic [VW-1:0] s_run;
    logic          e_upd;
    vent_t         ent_in, ent_new;
    logic          cand;
    logic [SW-1:0] sum_w;

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            emem[e_waddr] <= e_wdata;
        end
        if (e_re)
        begin
            erdata_reg <= emem[e_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vmem[v_waddr] <= v_wdata;
        end
        if (v_re)
        begin
            vrdata_reg <= vmem[v_raddr];
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign edge_ok  = (32'(from_vertex) < MAX_VERTICES) && (32'(to_vertex) < MAX_VERTICES);

    // clamp vertex count and start for a new run
    always_comb
    begin
        if (cfg.vertex_count == 5'd0)
        begin
            n_run = 6'd1;
        end
        else if ({1'b0, cfg.vertex_count} > NMAX_N)
        begin
            n_run = NMAX_N;
        end
        else
        begin
            n_run = {1'b0, cfg.vertex_count};
        end
        nl_run = VW'(n_run - 6'd1);
        s_run  = ({2'b00, cfg.start_vertex} >= n_run) ? '0 : VW'(cfg.start_vertex);
    end

    // edge keeps the lower weight
    assign e_upd = !erdata_reg[WEIGHT_BITS]
                   || (erdata_reg[WEIGHT_BITS-1:0] > w_reg);

    // relax one vertex entry against the current tree vertex
    always_comb
    begin
        if (first_reg)
        begin
            ent_in.tree   = 1'b0;
            ent_in.parent = '0;
            ent_in.weight = DIST_INF;
        end
        else
        begin
            ent_in = vrdata_reg;
        end
        ent_new = ent_in;
        if (p_k_reg == v_reg)
        begin
            ent_new.tree = 1'b1;
            if (first_reg)
            begin
                ent_new.weight = '0;
            end
        end
        else if (!ent_in.tree && erdata_reg[WEIGHT_BITS]
                 && (ent_in.weight > {1'b0, erdata_reg[WEIGHT_BITS-1:0]}))
        begin
            ent_new.weight = {1'b0, erdata_reg[WEIGHT_BITS-1:0]};
            ent_new.parent = v_reg;
        end
        cand = p_vld_reg && !ent_new.tree && (ent_new.weight < best_d_reg);
    end

    assign sum_w = SW'(total_reg) + SW'(vrdata_reg.weight);

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        v_next      = v_reg;
        k_next      = k_reg;
        nl_next     = nl_reg;
        s_next      = s_reg;
        first_next  = first_reg;
        best_d_next = cand ? ent_new.weight : best_d_reg;
        best_v_next = cand ? p_k_reg : best_v_reg;
        found_next  = found_reg || cand;
        p_vld_next  = 1'b0;
        p_k_next    = p_k_reg;
        total_next  = total_reg;
        dir_next    = dir_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        w_next      = w_reg;

        e_we    = 1'b0;
        e_re    = 1'b0;
        e_waddr = {a_reg, b_reg};
        e_raddr = {v_reg, k_reg};
        e_wdata = {1'b1, w_reg};
        v_we    = p_vld_reg;
        v_waddr = p_k_reg;
        v_wdata = ent_new;
        v_re    = 1'b0;
        v_raddr = k_reg;

        push      = 1'b0;
        push_data = '0;

        case (state_reg)
            S_CLEAR:
            begin
                e_we     = 1'b1;
                e_waddr  = clr_reg;
                e_wdata  = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == {AW{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept && !req_type && edge_ok)
                begin
                    a_next     = VW'(from_vertex);
                    b_next     = VW'(to_vertex);
                    w_next     = WEIGHT_BITS'(edge_weight);
                    dir_next   = cfg.directed;
                    e_re       = 1'b1;
                    e_raddr    = {VW'(from_vertex), VW'(to_vertex)};
                    state_next = S_EWR1;
                end
                else if (accept && req_type)
                begin
                    nl_next     = nl_run;
                    s_next      = s_run;
                    v_next      = s_run;
                    k_next      = '0;
                    first_next  = 1'b1;
                    best_d_next = DIST_INF;
                    found_next  = 1'b0;
                    total_next  = '0;
                    state_next  = S_PISSUE;
                end
            end
            S_EWR1:
            begin
                e_we       = e_upd;
                state_next = dir_reg ? S_IDLE : S_ERD2;
            end
            S_ERD2:
            begin
                e_re       = 1'b1;
                e_raddr    = {b_reg, a_reg};
                state_next = S_EWR2;
            end
            S_EWR2:
            begin
                e_we       = e_upd;
                e_waddr    = {b_reg, a_reg};
                state_next = S_IDLE;
            end
            S_PISSUE:
            begin
                e_re       = 1'b1;
                v_re       = 1'b1;
                p_vld_next = 1'b1;
                p_k_next   = k_reg;
                if (k_reg == nl_reg)
                begin
                    state_next = S_PFIN;
                end
                else
                begin
                    k_next = k_reg + VW'(1);
                end
            end
            S_PFIN:
            begin
                // last entry of the pass retires here, then pick the next vertex or start reporting
                k_next     = '0;
                first_next = 1'b0;
                if (found_reg || cand)
                begin
                    v_next      = best_v_next;
                    best_d_next = DIST_INF;
                    found_next  = 1'b0;
                    state_next  = S_PISSUE;
                end
                else
                begin
                    state_next = S_RRD;
                end
            end
            S_RRD:
            begin
                if (k_reg == s_reg)
                begin
                    if (k_reg == nl_reg)
                    begin
                        state_next = S_SUM;
                    end
                    else
                    begin
                        k_next = k_reg + VW'(1);
                    end
                end
                else
                begin
                    v_re       = 1'b1;
                    state_next = S_RLOAD;
                end
            end
            S_RLOAD:
            begin
                if (out_free)
                begin
                    push                   = 1'b1;
                    push_data.child_vertex = VERTEX_W'(k_reg);
                    push_data.reached      = vrdata_reg.tree;
                    if (vrdata_reg.tree)
                    begin
                        push_data.parent_vertex    = VERTEX_W'(vrdata_reg.parent);
                        push_data.tree_edge_weight = WEIGHT_IN_W'(vrdata_reg.weight);
                        total_next = (sum_w > SW'(COST_MAX)) ? COST_MAX : COST_W'(sum_w);
                    end
                    if (k_reg == nl_reg)
                    begin
                        state_next = S_SUM;
                    end
                    else
                    begin
                        k_next     = k_reg + VW'(1);
                        state_next = S_RRD;
                    end
                end
            end
            S_SUM:
            begin
                if (out_free)
                begin
                    push                 = 1'b1;
                    push_data.total_cost = total_reg;
                    push_data.last       = 1'b1;
                    clr_next             = '0;
                    state_next           = S_CLEAR;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            v_reg      <= '0;
            k_reg      <= '0;
            nl_reg     <= '0;
            s_reg      <= '0;
            first_reg  <= 1'b0;
            best_d_reg <= DIST_INF;
            best_v_reg <= '0;
            found_reg  <= 1'b0;
            p_vld_reg  <= 1'b0;
            p_k_reg    <= '0;
            total_reg  <= '0;
            dir_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            v_reg      <= v_next;
            k_reg      <= k_next;
            nl_reg     <= nl_next;
            s_reg      <= s_next;
            first_reg  <= first_next;
            best_d_reg <= best_d_next;
            best_v_reg <= best_v_next;
            found_reg  <= found_next;
            p_vld_reg  <= p_vld_next;
            p_k_reg    <= p_k_next;
            total_reg  <= total_next;
            dir_reg    <= dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        w_reg <= w_next;
    end

    `PMST_ASSERT_IMP(a_push_free, push, out_free, "push into full output stage")
    `PMST_ASSERT_IMP(a_vert_overlap, v_we && v_re, v_waddr != v_raddr, "vertex entry overlap")
    `PMST_ASSERT_NXT(a_clear_after_sum, push && push_data.last, state_reg == S_CLEAR, "no clear")
    `PMST_ASSERT_IMP(a_pipe_in_pass, p_vld_reg, state_reg == S_PISSUE || state_reg == S_PFIN, "relax")

endmodule

// File: rtl/pmst_out.sv
// output holding register of the spanning tree core
module pmst_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pmst_pkg::result_t push_data,
    input  logic              out_stall,
    output logic              out_free,
    output logic              out_valid,
    output pmst_pkg::result_t out_data
);
    import pmst_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg, data_next;

    assign out_free   = !valid_reg || !out_stall;
    assign valid_next = push || (valid_reg && out_stall);
    assign data_next  = push ? push_data : data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/prim_minimum_spanning_tree_core.sv
// top level of the prim minimum spanning tree core
// usage:
//  - input channel (in_valid/in_stall) carries one transaction per item; req_type 0
//    loads a weighted edge, req_type 1 runs prim from start_vertex and reports
//  - an edge transaction is a read-modify-write of the edge memory, a second one for
//    the reverse entry if undirected; lower weight wins on parallel edges
//  - a run takes up to n passes (n = clamped vertex_count), one edge row and the
//    vertex table walked per pass, then an S_RRD read and an S_RLOAD push per reported
//    vertex and one summary transaction with last set and the total cost
//  - result transactions leave on out_valid/out_stall in ascending vertex order,
//    the start vertex skipped; a stalled result holds and the sequencer waits
//  - after the summary the edge memory is swept clear, one entry per cycle over all
//    2^(2*clog2(MAX_VERTICES)) entries (256 at the default size)
//  - reset runs the same clearing sweep; in_stall stays high until it is done
//  - configuration goes over the apb port: vertex_count at 0x0, start_vertex at
//    0x4, directed at 0x8; write it only while the core is idle
module prim_minimum_spanning_tree_core #(
    parameter int MAX_VERTICES = 16,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pmst_pkg::ADDR_W-1:0]      paddr,
    input  logic [pmst_pkg::DATA_W-1:0]      pwdata,
    output logic [pmst_pkg::DATA_W-1:0]      prdata,
    output logic                             pready,
    // input transactions
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             req_type,
    input  logic [pmst_pkg::VERTEX_W-1:0]    from_vertex,
    input  logic [pmst_pkg::VERTEX_W-1:0]    to_vertex,
    input  logic [pmst_pkg::WEIGHT_IN_W-1:0] edge_weight,
    // result transactions
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [pmst_pkg::VERTEX_W-1:0]    parent_vertex,
    output logic [pmst_pkg::VERTEX_W-1:0]    child_vertex,
    output logic [pmst_pkg::WEIGHT_IN_W-1:0] tree_edge_weight,
    output logic                             reached,
    output logic [pmst_pkg::COST_W-1:0]      total_cost,
    output logic                             last
);
    import pmst_pkg::*;

    cfg_t    cfg;
    logic    out_free;
    logic    push;
    result_t push_data;
    result_t out_data;

    // register file
    pmst_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // edge memory, vertex table and the prim sequencer
    pmst_engine #(
        .MAX_VERTICES (MAX_VERTICES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .from_vertex (from_vertex),
        .to_vertex   (to_vertex),
        .edge_weight (edge_weight),
        .out_free    (out_free),
        .push        (push),
        .push_data   (push_data)
    );

    // result register, decouples the sequencer from a stalling receiver
    pmst_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .out_stall (out_stall),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign parent_vertex    = out_data.parent_vertex;
    assign child_vertex     = out_data.child_vertex;
    assign tree_edge_weight = out_data.tree_edge_weight;
    assign reached          = out_data.reached;
    assign total_cost       = out_data.total_cost;
    assign last             = out_data.last;

endmodule
